/* sv/fcds_pkg.sv */
// fcds_pkg: shared types and constants of the fractional clock divider search
// no dependencies
`timescale 1ns / 1ps
package fcds_pkg;
    localparam int FRAC_BITS = 24;
    localparam logic [31:0] ERR_SAT = 32'h7FFF_FFFF;
    localparam logic [31:0] BASE_RESET = 32'd160000000;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_FRAC, S_NORM, S_CAND, S_MUL, S_SDIV, S_EVAL, S_DONE
    } t_state;

    // request to the serial divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;
endpackage

/* sv/fcds_div.sv */
// fcds_div: restoring divider, one quotient bit per cycle, 64 bits
// depends on fcds_pkg
`timescale 1ns / 1ps
module fcds_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcds_pkg::t_div_req i_req,
    output fcds_pkg::t_div_rsp o_rsp
);
    logic [63:0] r_q, n_q;
    logic [64:0] r_r, n_r;
    logic [63:0] r_d;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [64:0] w_sh;

    always_comb begin
        w_sh = {r_r[63:0], r_q[63]};
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_q = i_req.num; n_r = '0; n_cnt = 7'd64; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_d}) begin
                n_r = w_sh - {1'b0, r_d};
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_r = w_sh;
                n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r;
        if (i_req.start) r_d <= i_req.den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_r[63:0];
endmodule

/* sv/fractional_clock_divider_search_top.sv */
// fractional_clock_divider_search_top: divider search controller and i/o
// depends on fcds_pkg and fcds_div
`timescale 1ns / 1ps
// usage:
//  - s_axis carries target_freq (bits 30:0 of tdata); one transaction starts
//    one search, and m_axis returns one transaction with the divider found:
//    tdata = {div_numerator, div_denominator, div_integer}, div_integer at bit 0
//  - cfg channel writes base_clock; write only while no search is running
//  - all wide divisions share one bit-serial 64-bit divider
//  - a search runs the quotient and fraction divides and normalization,
//    then per denominator candidate a setup step, a serial multiply, two
//    divides and a compare; a skipped candidate takes only the setup step
//  - the small ratio and zero target cases go straight to the output stage;
//    a too large quotient ends the search after the first divide
//  - one search at a time; s_axis_tready is high only while idle, so a new
//    transaction is taken the cycle after a result is handed to the output
//  - when the receiver stalls the result holds in the output register and
//    the next search may still run; a second finished search waits until
//    the output register frees, and the input stays blocked meanwhile
//  - reset restores base_clock to 160000000 and empties the pipeline
module fractional_clock_divider_search_top #(
    parameter int MAX_DENOM   = 63,
    parameter int MAX_INTEGER = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // target_freq[30:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // div_integer[7:0], div_denominator[13:8], div_numerator[19:14]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data      // base_clock
);
    localparam int AW = $clog2(MAX_DENOM + 1);
    localparam int NW = $clog2(MAX_INTEGER + 1);
    localparam int CW = (AW > 1) ? $clog2(AW) : 1;

    fcds_pkg::t_state r_st, n_st;
    fcds_pkg::t_div_req w_req;
    fcds_pkg::t_div_rsp w_rsp;

    logic [31:0] r_base;
    logic [30:0] r_tgt;
    logic [31:0] r_t;        // normalized target
    logic [4:0]  r_k;
    logic [NW-1:0] r_n;
    logic [23:0] r_frac;
    logic [AW:0] r_a;        // current denominator, 0 = n+1 candidate
    logic [AW-1:0] r_b;
    logic [63:0] r_prod;     // base * a
    logic [63:0] r_q0;       // first partial quotient
    logic [63:0] r_den;
    logic [31:0] r_best;
    logic [NW-1:0] r_rn;
    logic [AW-1:0] r_ra, r_rb;
    logic [NW-1:0] r_out_n;  // output register
    logic [AW-1:0] r_out_a, r_out_b;
    logic        r_out_v;
    logic        r_phase;    // 0 first divide, 1 remainder divide
    logic        r_dph;      // divider started for current step
    logic [CW-1:0] r_mcnt;
    logic [63:0] r_mshift;
    logic [AW-1:0] r_mult;

    logic [63:0] w_val, w_e;
    logic [31:0] w_err;
    logic [AW+24:0] w_bfull;
    logic [AW:0] w_bcalc;
    logic [NW+AW-1:0] w_na;
    logic        w_small;
    logic        w_out_load;

    assign s_axis_tready = (r_st == fcds_pkg::S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {4'd0, 6'(r_out_b), 6'(r_out_a), 8'(r_out_n)};

    // base <= 2 * target
    assign w_small    = (33'(r_base) <= {1'b0, s_axis_tdata[30:0], 1'b0});
    assign w_out_load = (r_st == fcds_pkg::S_DONE) && (!r_out_v || m_axis_tready);

    always_comb begin
        w_bfull = ({1'b0, r_a[AW-1:0]} * r_frac) + (AW+25)'(1 << (fcds_pkg::FRAC_BITS - 1));
        w_bcalc = (AW+1)'(w_bfull >> fcds_pkg::FRAC_BITS);
        w_na    = r_n * r_a[AW-1:0];
        w_val   = (r_q0 << r_k) + w_rsp.quo;
        w_e     = (64'(r_t) >= w_val) ? 64'(r_t) - w_val : w_val - 64'(r_t);
        w_err   = (w_e > 64'(fcds_pkg::ERR_SAT)) ? fcds_pkg::ERR_SAT : w_e[31:0];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            fcds_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                if (w_small || s_axis_tdata[30:0] == '0) n_st = fcds_pkg::S_DONE;
                else n_st = fcds_pkg::S_DIV;
            end
            fcds_pkg::S_DIV: if (w_rsp.done) begin
                if (w_rsp.quo > 64'(MAX_INTEGER)) n_st = fcds_pkg::S_DONE;
                else n_st = fcds_pkg::S_FRAC;
            end
            fcds_pkg::S_FRAC: if (w_rsp.done) n_st = fcds_pkg::S_NORM;
            fcds_pkg::S_NORM: if (r_t[31]) n_st = fcds_pkg::S_CAND;
            fcds_pkg::S_CAND: begin
                if (32'(r_a) > 32'(MAX_DENOM)) n_st = fcds_pkg::S_DONE;
                else if (r_a != '0 && w_bcalc >= r_a) n_st = fcds_pkg::S_CAND;
                else n_st = fcds_pkg::S_MUL;
            end
            fcds_pkg::S_MUL:  if (r_mcnt == '0) n_st = fcds_pkg::S_SDIV;
            fcds_pkg::S_SDIV: if (w_rsp.done && r_phase) n_st = fcds_pkg::S_EVAL;
            fcds_pkg::S_EVAL: begin
                if (w_err < r_best && w_err == '0 && r_a != '0) n_st = fcds_pkg::S_DONE;
                else n_st = fcds_pkg::S_CAND;
            end
            fcds_pkg::S_DONE: if (!r_out_v || m_axis_tready) n_st = fcds_pkg::S_IDLE;
            default:          n_st = fcds_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = '0;
        w_req.den   = 64'd1;
        if (r_st == fcds_pkg::S_DIV && !r_dph) begin
            w_req.start = 1'b1; w_req.num = 64'(r_base); w_req.den = 64'(r_tgt);
        end else if (r_st == fcds_pkg::S_FRAC && !r_dph) begin
            w_req.start = 1'b1; w_req.num = {9'd0, w_rsp.rem[30:0], 24'd0};
            w_req.den = 64'(r_tgt);
        end else if (r_st == fcds_pkg::S_SDIV && !r_dph) begin
            w_req.start = 1'b1; w_req.den = r_den;
            w_req.num = r_phase ? (w_rsp.rem << r_k) : r_prod;
        end
    end

    fcds_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= fcds_pkg::S_IDLE; r_base <= fcds_pkg::BASE_RESET;
            r_out_v <= 1'b0; r_dph <= 1'b0; r_phase <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) r_base <= i_cfg_data;
            if (w_out_load) r_out_v <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_v <= 1'b0;
            if (w_req.start) r_dph <= 1'b1;
            else if (w_rsp.done || r_st == fcds_pkg::S_IDLE) r_dph <= 1'b0;
            unique case (r_st)
                fcds_pkg::S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_tgt <= s_axis_tdata[30:0];
                        r_t <= {1'b0, s_axis_tdata[30:0]};
                        r_k <= '0;
                        r_best <= 32'hFFFF_FFFF;
                        if (w_small) begin
                            r_rn <= NW'(2); r_ra <= AW'(1); r_rb <= '0;
                        end else begin
                            r_rn <= NW'(MAX_INTEGER); r_ra <= AW'(MAX_DENOM);
                            r_rb <= AW'(MAX_DENOM - 1);
                        end
                    end
                end
                fcds_pkg::S_DIV: if (w_rsp.done) r_n <= NW'(w_rsp.quo);
                fcds_pkg::S_FRAC: if (w_rsp.done) begin
                    r_frac <= w_rsp.quo[23:0];
                    r_a <= (32'(r_n) < 32'(MAX_INTEGER)) ? '0 : (AW+1)'(1);
                end
                fcds_pkg::S_NORM: if (!r_t[31]) begin
                    r_t <= r_t << 1; r_k <= r_k + 5'd1;
                end
                fcds_pkg::S_CAND: begin
                    r_phase <= 1'b0;
                    if (r_a == '0) begin
                        r_b <= '0; r_mult <= AW'(1);
                        r_den <= 64'(r_n) + 64'd1;
                    end else begin
                        r_b <= AW'(w_bcalc);
                        r_mult <= r_a[AW-1:0];
                        r_den <= 64'(w_na) + 64'(w_bcalc);
                        // numerator reaching the denominator skips this candidate
                        if (w_bcalc >= r_a) r_a <= r_a + 1'b1;
                    end
                    r_mcnt <= CW'(AW - 1);
                    r_prod <= '0; r_mshift <= 64'(r_base) << (AW - 1);
                end
                fcds_pkg::S_MUL: begin
                    // serial shift-add multiply, one denominator bit a cycle
                    if (r_mult[r_mcnt]) r_prod <= r_prod + r_mshift;
                    r_mshift <= r_mshift >> 1;
                    if (r_mcnt != '0) r_mcnt <= r_mcnt - CW'(1);
                end
                fcds_pkg::S_SDIV: if (w_rsp.done && !r_phase) begin
                    r_q0 <= w_rsp.quo; r_phase <= 1'b1;
                end
                fcds_pkg::S_EVAL: begin
                    r_a <= r_a + 1'b1;
                    if (w_err < r_best) begin
                        r_best <= w_err;
                        r_rb <= r_b;
                        if (r_a == '0) begin
                            r_rn <= r_n + 1'b1; r_ra <= AW'(1);
                        end else begin
                            r_rn <= r_n; r_ra <= r_a[AW-1:0];
                        end
                    end
                end
                fcds_pkg::S_DONE: if (w_out_load) begin
                    r_out_n <= r_rn; r_out_a <= r_ra; r_out_b <= r_rb;
                end
                default: ;
            endcase
        end
    end
endmodule

/* sim/testbench.sv */
// testbench: self-checking bench for fractional_clock_divider_search_top
// depends on fcds_pkg and the divider search rtl
`timescale 1ns / 1ps
module testbench;
    localparam int MAX_DENOM   = 63;
    localparam int MAX_INTEGER = 255;
    localparam longint CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic [5:0] numer;
        logic [5:0] denom;
        logic [7:0] integ;
    } t_divider;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    logic [31:0] base_clock_model;
    t_divider    expected_dividers[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          targets_sent = 0;
    longint      cycles = 0;

    fractional_clock_divider_search_top #(
        .MAX_DENOM  (MAX_DENOM),
        .MAX_INTEGER(MAX_INTEGER)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("fractional_clock_divider_search_top: mismatch");
            $finish;
        end
    end

    // error of one candidate against the normalized target, saturated
    function automatic logic [31:0] candidate_error(logic [63:0] base, logic [63:0] mult,
                                                    int k, logic [63:0] den, logic [63:0] t);
        logic [63:0] p, q, r, v, e;
        p = base * mult;
        q = p / den;
        r = p % den;
        v = (q << k) + ((r << k) / den);
        e = (t >= v) ? t - v : v - t;
        return (e > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : e[31:0];
    endfunction

    function automatic t_divider search_divider(logic [31:0] base_clk, logic [30:0] target);
        logic [63:0] base, tgt, n, rem, frac, t, b;
        logic [31:0] best, e;
        t_divider    res;
        int          k;
        base = base_clk;
        tgt = target;
        res = '{numer: 6'(MAX_DENOM - 1), denom: 6'(MAX_DENOM), integ: 8'(MAX_INTEGER)};
        if (base <= (tgt << 1))
            return '{numer: 6'd0, denom: 6'd1, integ: 8'd2};
        if (tgt == 0)
            return res;
        n = base / tgt;
        if (n > MAX_INTEGER)
            return res;
        rem = base % tgt;
        frac = (rem << 24) / tgt;
        t = tgt;
        k = 0;
        while (t[31] == 1'b0) begin
            t = t << 1;
            k++;
        end
        best = 32'hFFFF_FFFF;
        if (n < MAX_INTEGER) begin
            res = '{numer: 6'd0, denom: 6'd1, integ: 8'(n + 1)};
            best = candidate_error(base, 1, k, n + 1, t);
        end
        for (int a = 1; a <= MAX_DENOM; a++) begin
            b = (a * frac + 64'h80_0000) >> 24;
            if (b >= a)
                continue;
            e = candidate_error(base, a, k, n * a + b, t);
            if (best <= e)
                continue;
            best = e;
            res = '{numer: 6'(b), denom: 6'(a), integ: 8'(n)};
            if (e == 0)
                break;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // one search request; expectation is queued at the accepting edge
    task automatic send_target(logic [30:0] target);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, target};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        expected_dividers.push_back(search_divider(base_clock_model, target));
        targets_sent++;
    endtask

    // receiver readiness: random idling or a long counted hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_divider got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[19:0];
            if (expected_dividers.size() == 0) begin
                $display("unexpected result transaction");
                mismatches++;
            end else begin
                want = expected_dividers.pop_front();
                if (got.integ != want.integ)
                    report_mismatch("div_integer", got.integ, want.integ);
                if (got.denom != want.denom)
                    report_mismatch("div_denominator", got.denom, want.denom);
                if (got.numer != want.numer)
                    report_mismatch("div_numerator", got.numer, want.numer);
            end
            results_seen++;
        end
    end

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_dividers.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // base clock write, only with the search idle
    task automatic write_base_clock(logic [31:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        base_clock_model = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_special_cases();
        // reset value of base clock first
        send_target(31'd0);
        send_target(31'(44100 * 256));
        send_target(31'd80000000);
        send_target(31'h7FFF_FFFF);
        send_target(31'd1);
        send_target(31'(160000000 / 255));
        send_target(31'(160000000 / 255 + 1));
        send_target(31'(160000000 / 256));
        send_target(31'd10000000);
        send_target(31'd3000000);
        write_base_clock(32'hFFFF_FFFF);
        send_target(31'h7FFF_FFFF);
        send_target(31'd16843010);
        send_target(31'd16843009);
        send_target(31'h5555_5555);
        write_base_clock(32'd1);
        send_target(31'd0);
        send_target(31'd1);
        write_base_clock(32'd0);
        send_target(31'd0);
        send_target(31'd12345);
        write_base_clock(32'd1000);
        send_target(31'd7);
        send_target(31'd3);
        send_target(31'd333);
    endtask

    function automatic logic [30:0] random_target(logic [31:0] base);
        int unsigned n;
        case ($urandom_range(9))
            0: return 31'($urandom);
            1: return '0;
            default: begin
                // mostly ratios inside the searched range
                n = $urandom_range(MAX_INTEGER, 2);
                if (base / n == 0)
                    return 31'($urandom_range(3));
                return 31'($urandom_range(base / n, base / (n + 1)));
            end
        endcase
    endfunction

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 10 == 0)
                write_base_clock(($urandom_range(3) == 0) ? $urandom :
                                 32'($urandom_range(200000000, 1000000)));
            send_target(random_target(base_clock_model));
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_off = 30000;
        for (int i = 0; i < 4; i++)
            send_target(random_target(base_clock_model));
    endtask

    initial begin
        base_clock_model = 32'd160000000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 37;
        recv_idle_pct = 77;
        test_special_cases();
        test_random(30);
        send_idle_pct = 77;
        recv_idle_pct = 37;
        test_random(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(30);
        drain();
        $display("covered %0d searches, %0d results, special cases and long output stall",
                 targets_sent, results_seen);
        if (mismatches == 0)
            $display("fractional_clock_divider_search_top: match");
        else
            $display("fractional_clock_divider_search_top: mismatch");
        $finish;
    end
endmodule
